// ----- rtl/afs_pkg.sv -----
package afs_pkg;

   // action codes carried by an input item
   typedef enum logic [2:0] {
      ACT_TICK       = 3'd0,
      ACT_START      = 3'd1,
      ACT_SET_PAUSE  = 3'd2,
      ACT_STEP_BACK  = 3'd3,
      ACT_STEP_FWD   = 3'd4,
      ACT_STOP       = 3'd5
   } action_type;

   // playback mode codes
   typedef enum logic [2:0] {
      MODE_ONCE      = 3'd0,
      MODE_LOOP      = 3'd1,
      MODE_PING_UP   = 3'd2,
      MODE_PING_DOWN = 3'd3,
      MODE_REVERSE   = 3'd4
   } mode_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_MODE         = 2'd0,
      CSR_FRAME_COUNT  = 2'd1,
      CSR_FRAME_PERIOD = 2'd2
   } csr_index_type;

   localparam int unsigned IndexWidth  = 8;
   localparam int unsigned CountWidth  = 9;
   localparam int unsigned PeriodWidth = 16;
   localparam int unsigned ModeWidth   = 3;
   localparam int unsigned CsrWidth    = 16;

   // one result item
   typedef struct packed {
      logic [IndexWidth-1:0] frame_index;
      logic                  is_done;
      logic                  is_paused;
      logic                  going_down;
      logic                  advanced;
   } result_type;

endpackage

// ----- rtl/animation_frame_sequencer_core.sv -----
// an accepted item's result is registered in the output register, or in the skid register
// while the output is stalled; throughput: one item per cycle while req_stall is low; the
// whole state update is one pass of logic into the state and result registers, and the skid
// register lets an item in while a result is stalled
// reset (synchronous, active high): index 0, done set, not paused, counting up,
// countdown 0, mode once, frame_count 1, frame_period 0, no result pending
module animation_frame_sequencer_core #(
   parameter int unsigned MAX_FRAMES = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   // input items
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_action,
   input  logic [7:0]                         req_start_index,
   input  logic                               req_pause_value,
   // result items
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_frame_index,
   output logic                               rsp_is_done,
   output logic                               rsp_is_paused,
   output logic                               rsp_going_down,
   output logic                               rsp_advanced,
   // configuration writes
   input  logic                               csr_wr_en,
   input  logic [1:0]                         csr_index,
   input  logic [afs_pkg::CsrWidth-1:0]       csr_wdata
);

   localparam int unsigned IW = afs_pkg::IndexWidth;
   localparam int unsigned CW = afs_pkg::CountWidth;
   localparam int unsigned PW = afs_pkg::PeriodWidth;
   localparam int unsigned MW = afs_pkg::ModeWidth;

   // upper clamp of the frame count: the smaller of MAX_FRAMES and the index range
   localparam int unsigned CountLimitInt = (MAX_FRAMES > 256) ? 256 : MAX_FRAMES;
   localparam logic [CW-1:0] CountLimit = CW'(CountLimitInt);

   // configuration registers
   logic [MW-1:0] mode_ff,   mode_in;
   logic [CW-1:0] count_ff,  count_in;
   logic [PW-1:0] period_ff, period_in;

   // sequencer state
   logic [IW-1:0] index_ff,  index_in;
   logic          down_ff,   down_in;
   logic          done_ff,   done_in;
   logic          pause_ff,  pause_in;
   logic [PW-1:0] cdown_ff,  cdown_in;

   // output register and skid register
   afs_pkg::result_type out_ff,   out_in;
   afs_pkg::result_type skid_ff,  skid_in;
   logic                out_vld_ff,  out_vld_in;
   logic                skid_vld_ff, skid_vld_in;

   logic                req_take;
   logic                out_free;
   afs_pkg::result_type res;

   // effective frame count, clamped to 1..limit
   logic [CW-1:0] eff_count;
   logic [IW-1:0] last_index;
   logic [CW-1:0] index_plus;
   logic          at_end;

   // advance outcome
   logic [IW-1:0] adv_index;
   logic          adv_down;
   logic          adv_done;

   always_comb begin
      if (count_ff == '0) begin
         eff_count = CW'(1);
      end else if (count_ff > CountLimit) begin
         eff_count = CountLimit;
      end else begin
         eff_count = count_ff;
      end
      last_index = IW'(eff_count - CW'(1));
      index_plus = {1'b0, index_ff} + CW'(1);
      at_end     = (index_plus >= eff_count);
   end

   // one advance step per the current mode
   always_comb begin
      adv_index = index_ff;
      adv_down  = down_ff;
      adv_done  = done_ff;
      if (!done_ff) begin
         case (mode_ff)
            afs_pkg::MODE_ONCE: begin
               if (at_end) begin
                  adv_done  = 1'b1;
                  adv_index = last_index;
               end else begin
                  adv_index = IW'(index_plus);
               end
            end
            afs_pkg::MODE_LOOP: begin
               adv_index = at_end ? '0 : IW'(index_plus);
            end
            afs_pkg::MODE_PING_UP, afs_pkg::MODE_PING_DOWN: begin
               if (eff_count < CW'(2)) begin
                  // too few frames to bounce: park at frame zero
                  adv_index = '0;
               end else if (!down_ff) begin
                  if (at_end) begin
                     adv_index = IW'(eff_count - CW'(2));
                     adv_down  = 1'b1;
                  end else begin
                     adv_index = IW'(index_plus);
                  end
               end else if (index_ff == '0) begin
                  // already at the bottom while heading down: bounce up
                  adv_index = IW'(1);
                  adv_down  = 1'b0;
               end else begin
                  adv_index = index_ff - IW'(1);
                  if (index_ff == IW'(1)) begin
                     adv_down = 1'b0;
                  end
               end
            end
            afs_pkg::MODE_REVERSE: begin
               adv_index = (index_ff == '0) ? last_index : index_ff - IW'(1);
            end
            default: begin
               adv_index = index_ff;
            end
         endcase
      end
   end

   assign req_take  = req_valid && !req_stall;
   assign req_stall = skid_vld_ff;

   // next state from configuration writes and the accepted item
   always_comb begin
      mode_in   = mode_ff;
      count_in  = count_ff;
      period_in = period_ff;
      index_in  = index_ff;
      down_in   = down_ff;
      done_in   = done_ff;
      pause_in  = pause_ff;
      cdown_in  = cdown_ff;

      if (csr_wr_en) begin
         case (csr_index)
            afs_pkg::CSR_MODE: begin
               mode_in = csr_wdata[MW-1:0];
               if (csr_wdata[MW-1:0] <= afs_pkg::MODE_PING_UP) begin
                  down_in = 1'b0;
                  done_in = 1'b0;
               end else begin
                  down_in = 1'b1;
               end
            end
            afs_pkg::CSR_FRAME_COUNT:  count_in  = csr_wdata[CW-1:0];
            afs_pkg::CSR_FRAME_PERIOD: period_in = csr_wdata[PW-1:0];
            default: begin
            end
         endcase
      end

      if (req_take) begin
         case (req_action)
            afs_pkg::ACT_TICK: begin
               if (cdown_ff != '0) begin
                  cdown_in = cdown_ff - PW'(1);
               end else if (!pause_ff && !done_ff) begin
                  index_in = adv_index;
                  down_in  = adv_down;
                  done_in  = adv_done;
                  cdown_in = period_ff;
               end
            end
            afs_pkg::ACT_START: begin
               index_in = (req_start_index > last_index) ? last_index : req_start_index;
               mode_in  = afs_pkg::MODE_ONCE;
               down_in  = 1'b0;
               pause_in = 1'b0;
               done_in  = 1'b0;
            end
            afs_pkg::ACT_SET_PAUSE: begin
               pause_in = req_pause_value;
            end
            afs_pkg::ACT_STEP_BACK: begin
               if (!done_ff) begin
                  index_in = (index_ff == '0) ? last_index : index_ff - IW'(1);
               end
            end
            afs_pkg::ACT_STEP_FWD: begin
               // ignores pause
               index_in = adv_index;
               down_in  = adv_down;
               done_in  = adv_done;
            end
            afs_pkg::ACT_STOP: begin
               done_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      res.frame_index = index_in;
      res.is_done     = done_in;
      res.is_paused   = pause_in;
      res.going_down  = down_in;
      res.advanced    = (index_in != index_ff);
   end

   // output register with a skid entry behind it
   assign out_free = !out_vld_ff || !rsp_stall;

   always_comb begin
      out_in      = out_ff;
      skid_in     = skid_ff;
      out_vld_in  = out_vld_ff && rsp_stall;
      skid_vld_in = skid_vld_ff;
      if (req_take) begin
         if (out_free) begin
            out_in     = res;
            out_vld_in = 1'b1;
         end else begin
            skid_in     = res;
            skid_vld_in = 1'b1;
         end
      end else if (skid_vld_ff && out_free) begin
         // drain the held item into the output register
         out_in      = skid_ff;
         out_vld_in  = 1'b1;
         skid_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= afs_pkg::MODE_ONCE;
         count_ff    <= CW'(1);
         period_ff   <= '0;
         index_ff    <= '0;
         down_ff     <= 1'b0;
         done_ff     <= 1'b1;
         pause_ff    <= 1'b0;
         cdown_ff    <= '0;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         count_ff    <= count_in;
         period_ff   <= period_in;
         index_ff    <= index_in;
         down_ff     <= down_in;
         done_ff     <= done_in;
         pause_ff    <= pause_in;
         cdown_ff    <= cdown_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_frame_index = out_ff.frame_index;
   assign rsp_is_done     = out_ff.is_done;
   assign rsp_is_paused   = out_ff.is_paused;
   assign rsp_going_down  = out_ff.going_down;
   assign rsp_advanced    = out_ff.advanced;

   // skid entry only fills behind a stalled output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid entry held without a pending output item");

   // a tick with time left only counts down
   a_tick_counts_down: assert property (@(posedge clock) disable iff (reset)
      (req_take && !csr_wr_en && req_action == afs_pkg::ACT_TICK && cdown_ff != '0)
      |=> (cdown_ff == $past(cdown_ff) - PW'(1)) && (index_ff == $past(index_ff)))
      else $error("countdown tick changed the frame index");

   // stop always leaves the sequence done
   a_stop_sets_done: assert property (@(posedge clock) disable iff (reset)
      (req_take && !csr_wr_en && req_action == afs_pkg::ACT_STOP) |=> done_ff)
      else $error("stop did not mark the sequence done");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned MaxFrames = 256;
   localparam int unsigned TotalItems = 1550;
   // the last stretch of items runs with no idling on either side
   localparam int unsigned QuietItems = 250;

   // action and mode codes that the package leaves unnamed
   localparam logic [2:0] ActSpareLow   = 3'd6;
   localparam logic [2:0] ActSpareHigh  = 3'd7;
   localparam logic [2:0] ModeSpareLow  = 3'd5;
   localparam logic [2:0] ModeSpareHigh = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // input item channel
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_action = '0;
   logic [7:0] req_start_index = '0;
   logic       req_pause_value = 1'b0;

   // result item channel
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_frame_index;
   logic       rsp_is_done;
   logic       rsp_is_paused;
   logic       rsp_going_down;
   logic       rsp_advanced;

   // register write port
   logic                         csr_wr_en = 1'b0;
   logic [1:0]                   csr_index = '0;
   logic [afs_pkg::CsrWidth-1:0] csr_wdata = '0;

   animation_frame_sequencer_core #(
      .MAX_FRAMES(MaxFrames)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_start_index(req_start_index),
      .req_pause_value(req_pause_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_index(rsp_frame_index),
      .rsp_is_done    (rsp_is_done),
      .rsp_is_paused  (rsp_is_paused),
      .rsp_going_down (rsp_going_down),
      .rsp_advanced   (rsp_advanced),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // sequencer model state, mirrors the block after every accepted item
   logic [2:0]  cur_mode   = afs_pkg::MODE_ONCE;
   logic [8:0]  cur_count  = 9'd1;
   logic [15:0] cur_period = '0;
   logic [7:0]  cur_index  = '0;
   logic        heading_down = 1'b0;
   logic        stopped    = 1'b1;
   logic        held       = 1'b0;
   logic [15:0] ticks_left = '0;

   afs_pkg::result_type frames_due[$];   // expected result items, oldest first
   int unsigned         wrong_fields = 0;
   int unsigned         items_sent = 0;
   bit                  gaps_on = 1'b1;  // sender may insert idle bursts
   bit                  stall_on = 1'b1; // receiver may stall in bursts
   int unsigned         stall_left = 0;
   afs_pkg::result_type oldest;

   // frames actually in play: frame_count clamped to 1..MaxFrames and 256
   function automatic int unsigned span();
      int unsigned c;
      c = cur_count;
      if (c < 1) c = 1;
      if (c > MaxFrames) c = MaxFrames;
      if (c > 256) c = 256;
      return c;
   endfunction

   // one advance of the index according to the current mode
   function automatic void next_frame();
      int unsigned c;
      int unsigned i;
      c = span();
      i = cur_index;
      if (stopped) return;
      case (cur_mode)
         afs_pkg::MODE_ONCE: begin
            // play once: hold on the last frame and mark done
            if (i + 1 >= c) begin
               stopped = 1'b1;
               i = c - 1;
            end else
               i = i + 1;
         end
         afs_pkg::MODE_LOOP: i = (i + 1 >= c) ? 0 : i + 1;
         afs_pkg::MODE_PING_UP, afs_pkg::MODE_PING_DOWN: begin
            if (c < 2) begin
               // ping-pong with a single frame sits at 0
               i = 0;
            end else if (!heading_down) begin
               if (i + 1 >= c) begin
                  i = c - 2;
                  heading_down = 1'b1;
               end else
                  i = i + 1;
            end else if (i == 0) begin
               // heading down but already at 0: turn and go to 1
               i = 1;
               heading_down = 1'b0;
            end else begin
               i = i - 1;
               if (i == 0) heading_down = 1'b0;
            end
         end
         afs_pkg::MODE_REVERSE: i = (i == 0) ? c - 1 : i - 1;
         default: ;   // spare modes leave the index where it is
      endcase
      cur_index = 8'(i);
   endfunction

   // state update for one accepted item, returns the result it should give
   function automatic afs_pkg::result_type play_step(logic [2:0] act, logic [7:0] sidx,
                                                     logic pv);
      logic [7:0]          was;
      int unsigned         c;
      afs_pkg::result_type r;
      was = cur_index;
      case (act)
         afs_pkg::ACT_TICK: begin
            if (ticks_left != 0)
               ticks_left = ticks_left - 16'd1;
            else if (!held && !stopped) begin
               next_frame();
               ticks_left = cur_period;
            end
         end
         afs_pkg::ACT_START: begin
            c = span();
            cur_index = (sidx > c - 1) ? 8'(c - 1) : sidx;
            cur_mode = afs_pkg::MODE_ONCE;
            heading_down = 1'b0;
            held = 1'b0;
            stopped = 1'b0;
         end
         afs_pkg::ACT_SET_PAUSE: held = pv;
         afs_pkg::ACT_STEP_BACK: begin
            if (!stopped) begin
               c = span();
               cur_index = (cur_index == 0) ? 8'(c - 1) : cur_index - 8'd1;
            end
         end
         afs_pkg::ACT_STEP_FWD: next_frame();
         afs_pkg::ACT_STOP: stopped = 1'b1;
         default: ;
      endcase
      r.frame_index = cur_index;
      r.is_done     = stopped;
      r.is_paused   = held;
      r.going_down  = heading_down;
      r.advanced    = (cur_index != was);
      return r;
   endfunction

   // register write, then wr_en low, so back-to-back writes never merge
   task automatic csr_write(input afs_pkg::csr_index_type idx, input logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         afs_pkg::CSR_MODE: begin
            cur_mode = value[2:0];
            if (value[2:0] <= afs_pkg::MODE_PING_UP) begin
               heading_down = 1'b0;
               stopped = 1'b0;
            end else
               heading_down = 1'b1;
         end
         afs_pkg::CSR_FRAME_COUNT:  cur_count = value[8:0];
         afs_pkg::CSR_FRAME_PERIOD: cur_period = value;
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // offer one item, wait for the handshake, then log what it should produce
   task automatic send_item(input logic [2:0] act, input logic [7:0] sidx, input logic pv,
                            input bit typed = 1'b0,
                            input afs_pkg::result_type want = '0);
      afs_pkg::result_type predicted;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_start_index <= sidx;
      req_pause_value <= pv;
      do @(posedge clock); while (req_stall);
      predicted = play_step(act, sidx, pv);
      frames_due.push_back(typed ? want : predicted);
      items_sent++;
   endtask

   // stop offering items and let every outstanding result come back
   task automatic drain();
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
   endtask

   // receiver stalls in bursts of random length while stall_on is set
   always @(posedge clock) begin
      if (stall_on && stall_left == 0 && $urandom_range(0, 7) == 0)
         stall_left = $urandom_range(1, 7);
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left = stall_left - 1;
      end else
         rsp_stall <= 1'b0;
   end

   // result checker: every accepted result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frames_due.size() == 0) begin
            $error("result item with nothing expected: frame_index %0d", rsp_frame_index);
            wrong_fields++;
         end else begin
            oldest = frames_due.pop_front();
            if (rsp_frame_index !== oldest.frame_index) begin
               $error("frame_index: expected %0d, got %0d", oldest.frame_index,
                      rsp_frame_index);
               wrong_fields++;
            end
            if (rsp_is_done !== oldest.is_done) begin
               $error("is_done: expected %0d, got %0d", oldest.is_done, rsp_is_done);
               wrong_fields++;
            end
            if (rsp_is_paused !== oldest.is_paused) begin
               $error("is_paused: expected %0d, got %0d", oldest.is_paused, rsp_is_paused);
               wrong_fields++;
            end
            if (rsp_going_down !== oldest.going_down) begin
               $error("going_down: expected %0d, got %0d", oldest.going_down,
                      rsp_going_down);
               wrong_fields++;
            end
            if (rsp_advanced !== oldest.advanced) begin
               $error("advanced: expected %0d, got %0d", oldest.advanced, rsp_advanced);
               wrong_fields++;
            end
         end
      end
   end

   // directed script: items and register writes in order
   typedef struct {
      bit                     is_write;
      logic [2:0]             action;
      logic [7:0]             start_index;
      logic                   pause_value;
      afs_pkg::csr_index_type reg_index;
      logic [15:0]            reg_value;
      bit                     typed;
      afs_pkg::result_type    want;
   } script_row;

   script_row script[$];

   function automatic void add_item(logic [2:0] act, logic [7:0] sidx, logic pv,
                                    bit typed = 1'b0, afs_pkg::result_type want = '0);
      script_row row;
      row = '{1'b0, act, sidx, pv, afs_pkg::CSR_MODE, 16'd0, typed, want};
      script.push_back(row);
   endfunction

   function automatic void add_write(afs_pkg::csr_index_type idx, logic [15:0] value);
      script_row row;
      row = '{1'b1, afs_pkg::ACT_TICK, 8'd0, 1'b0, idx, value, 1'b0,
              afs_pkg::result_type'(0)};
      script.push_back(row);
   endfunction

   initial begin
      int unsigned pick;
      int unsigned batch;
      logic [2:0]  act;
      logic [15:0] value;

      // out of reset: done, index 0, nothing should move
      add_item(afs_pkg::ACT_TICK, 8'd0, 1'b0, 1'b1,
               afs_pkg::result_type'{8'd0, 1'b1, 1'b0, 1'b0, 1'b0});
      add_item(afs_pkg::ACT_STEP_FWD, 8'd0, 1'b0, 1'b1,
               afs_pkg::result_type'{8'd0, 1'b1, 1'b0, 1'b0, 1'b0});
      add_item(afs_pkg::ACT_STEP_BACK, 8'd0, 1'b0, 1'b1,
               afs_pkg::result_type'{8'd0, 1'b1, 1'b0, 1'b0, 1'b0});
      add_item(ActSpareLow, 8'hff, 1'b1, 1'b1,
               afs_pkg::result_type'{8'd0, 1'b1, 1'b0, 1'b0, 1'b0});
      add_item(ActSpareHigh, 8'hff, 1'b1, 1'b1,
               afs_pkg::result_type'{8'd0, 1'b1, 1'b0, 1'b0, 1'b0});
      add_item(afs_pkg::ACT_SET_PAUSE, 8'd0, 1'b1, 1'b1,
               afs_pkg::result_type'{8'd0, 1'b1, 1'b1, 1'b0, 1'b0});
      // count of zero is treated as one frame, start saturates to it
      add_write(afs_pkg::CSR_FRAME_COUNT, 16'd0);
      add_write(afs_pkg::CSR_MODE, afs_pkg::MODE_ONCE);
      add_item(afs_pkg::ACT_START, 8'hff, 1'b0, 1'b1,
               afs_pkg::result_type'{8'd0, 1'b0, 1'b0, 1'b0, 1'b0});
      add_item(afs_pkg::ACT_TICK, 8'd0, 1'b0, 1'b1,
               afs_pkg::result_type'{8'd0, 1'b1, 1'b0, 1'b0, 1'b0});
      // oversized count clamps to 256 frames
      add_write(afs_pkg::CSR_FRAME_COUNT, 16'd511);
      add_item(afs_pkg::ACT_START, 8'hff, 1'b1, 1'b1,
               afs_pkg::result_type'{8'hff, 1'b0, 1'b0, 1'b0, 1'b1});
      add_item(afs_pkg::ACT_TICK, 8'd0, 1'b0, 1'b1,
               afs_pkg::result_type'{8'hff, 1'b1, 1'b0, 1'b0, 1'b0});
      // loop wraps both ways
      add_write(afs_pkg::CSR_MODE, afs_pkg::MODE_LOOP);
      add_item(afs_pkg::ACT_TICK, 8'd0, 1'b0, 1'b1,
               afs_pkg::result_type'{8'd0, 1'b0, 1'b0, 1'b0, 1'b1});
      add_item(afs_pkg::ACT_STEP_BACK, 8'd0, 1'b0, 1'b1,
               afs_pkg::result_type'{8'hff, 1'b0, 1'b0, 1'b0, 1'b1});
      add_item(afs_pkg::ACT_STEP_FWD, 8'd0, 1'b0);
      // paused ticks hold, step forward ignores the pause
      add_item(afs_pkg::ACT_SET_PAUSE, 8'd0, 1'b1);
      add_item(afs_pkg::ACT_TICK, 8'd0, 1'b0);
      add_item(afs_pkg::ACT_STEP_FWD, 8'd0, 1'b0);
      add_item(afs_pkg::ACT_SET_PAUSE, 8'd0, 1'b0);
      add_item(afs_pkg::ACT_STOP, 8'd0, 1'b0);
      // ping-pong heading down at index 0 turns and moves to 1, then countdown
      add_write(afs_pkg::CSR_FRAME_PERIOD, 16'd2);
      add_item(afs_pkg::ACT_START, 8'd0, 1'b0);
      add_write(afs_pkg::CSR_MODE, afs_pkg::MODE_PING_DOWN);
      repeat (4) add_item(afs_pkg::ACT_TICK, 8'd0, 1'b0);
      // ping-pong with one frame pins the index to 0
      add_write(afs_pkg::CSR_FRAME_COUNT, 16'd1);
      add_write(afs_pkg::CSR_MODE, afs_pkg::MODE_PING_UP);
      add_item(afs_pkg::ACT_STEP_FWD, 8'd0, 1'b0);
      // spare mode never moves the index
      add_write(afs_pkg::CSR_MODE, ModeSpareHigh);
      add_item(afs_pkg::ACT_STEP_FWD, 8'd0, 1'b0);
      // reverse loop from 0 wraps to the last frame
      add_write(afs_pkg::CSR_FRAME_COUNT, 16'd3);
      add_write(afs_pkg::CSR_MODE, afs_pkg::MODE_REVERSE);
      add_item(afs_pkg::ACT_STEP_FWD, 8'd0, 1'b0);
      add_write(afs_pkg::CSR_FRAME_PERIOD, 16'hffff);
      add_item(afs_pkg::ACT_TICK, 8'd0, 1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         if (script[k].is_write) begin
            drain();
            csr_write(script[k].reg_index, script[k].reg_value);
         end else
            send_item(script[k].action, script[k].start_index, script[k].pause_value,
                      script[k].typed, script[k].want);
      end

      // random phases: counts and period, usually a start, then a mode, then items
      while (items_sent < TotalItems) begin
         drain();
         if (items_sent + QuietItems >= TotalItems) begin
            gaps_on = 1'b0;
            stall_on = 1'b0;
         end else begin
            gaps_on = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
         end

         // frame count: extremes, short sequences, anything in the field
         case ($urandom_range(0, 9))
            0: value = 16'd0;
            1: value = 16'd1;
            2: value = 16'd2;
            3: value = 16'd256;
            4: value = 16'd511;
            5, 6, 7: value = 16'($urandom_range(2, 8));
            default: value = 16'($urandom_range(0, 511));
         endcase
         csr_write(afs_pkg::CSR_FRAME_COUNT, value);

         // period mostly short so advances happen often
         case ($urandom_range(0, 9))
            0: value = 16'hffff;
            1, 2: value = 16'd0;
            9: value = 16'($urandom);
            default: value = 16'($urandom_range(0, 3));
         endcase
         csr_write(afs_pkg::CSR_FRAME_PERIOD, value);

         if ($urandom_range(0, 3) != 0) begin
            send_item(afs_pkg::ACT_START, 8'($urandom), 1'($urandom));
            drain();
         end

         if ($urandom_range(0, 9) == 0)
            value = 16'($urandom_range(ModeSpareLow, ModeSpareHigh));
         else
            value = 16'($urandom_range(afs_pkg::MODE_ONCE, afs_pkg::MODE_REVERSE));
         csr_write(afs_pkg::CSR_MODE, value);

         batch = $urandom_range(10, 50);
         repeat (batch) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
               act = afs_pkg::ACT_TICK;
            else if (pick < 64)
               act = afs_pkg::ACT_STEP_FWD;
            else if (pick < 74)
               act = afs_pkg::ACT_STEP_BACK;
            else if (pick < 86)
               act = afs_pkg::ACT_SET_PAUSE;
            else if (pick < 92)
               act = afs_pkg::ACT_STOP;
            else if (pick < 97)
               act = afs_pkg::ACT_START;
            else
               act = ($urandom_range(0, 1) != 0) ? ActSpareLow : ActSpareHigh;
            send_item(act, 8'($urandom), 1'($urandom));
         end
      end

      drain();
      // spare cycles after the drain catch stray results
      repeat (5) @(posedge clock);
      if (wrong_fields == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // watchdog far beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
